// ===== rtl/stepper_speed_ramp_sequencer_top_macros.svh =====
// Assertion macros used by the checker in rtl/ssrseq_checker.sv.
`ifndef STEPPER_SPEED_RAMP_SEQUENCER_TOP_MACROS_SVH
`define STEPPER_SPEED_RAMP_SEQUENCER_TOP_MACROS_SVH

// Clocked property, masked while reset is applied.
`define SSRSEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds across reset.
`define SSRSEQ_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ssrseq_pkg.sv =====
package ssrseq_pkg;

  localparam logic       CMD_TICK  = 1'b0;
  localparam logic       CMD_RAMP  = 1'b1;
  localparam logic [3:0] COIL_STOP = 4'hF;
  localparam logic [7:0] SPEED_MAX = 8'hFF;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_DIV_CUR,
    DP_DIV_TGT,
    DP_DIV_NEW,
    DP_TICK_CLR,
    DP_TICK_STEP,
    DP_STOP,
    DP_SET_TGT,
    DP_OUT
  } dp_op_t;

  typedef enum logic [1:0] {
    DEST_CUR,
    DEST_TGT,
    DEST_SPD
  } div_dest_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic speed_zero;
    logic no_change;
    logic tgt_zero;
    logic same_dir;
    logic per_eq;
    logic cur_below_scale;
    logic new_p_zero;
    logic div_done;
  } dp_sts_t;

  // Coil bits a..d are bits 0..3; each phase sets one bit and clears another.
  function automatic logic [3:0] set_mask(input logic [1:0] ph);
    logic [3:0] m;
    case (ph)
      2'd0:    m = 4'h2;
      2'd1:    m = 4'h1;
      2'd2:    m = 4'h8;
      2'd3:    m = 4'h4;
      default: m = 4'h0;
    endcase
    return m;
  endfunction

  function automatic logic [3:0] clr_mask(input logic [1:0] ph);
    logic [3:0] m;
    case (ph)
      2'd0:    m = 4'h8;
      2'd1:    m = 4'h4;
      2'd2:    m = 4'h2;
      2'd3:    m = 4'h1;
      default: m = 4'h0;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/stepper_speed_ramp_sequencer_top.sv =====
// A ramp request needs up to three divisions on the shared one-bit-per-cycle divider,
// which works on DW bits, DW being the bit count of PERIOD_SCALE + 1 (at least 8).
// Only one request is handled at a time; the next is taken once the last has been
// handed to the output register, which waits while an earlier result is still held.
// Reset (synchronous, rst_n low): speed 0, forward, count 0, phase 0, coils all high.
module stepper_speed_ramp_sequencer_top import ssrseq_pkg::*; #(
  parameter int PERIOD_SCALE = 1500
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_command,
  input  logic [7:0] in_target_speed,
  input  logic       in_target_direction,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_coil_pattern,
  output logic [7:0] out_speed_now,
  output logic       out_direction_now,
  output logic       out_still_changing
);

  // Periods reach PERIOD_SCALE + 1; the divisor must also hold an 8-bit speed.
  localparam int PW_RAW = $clog2(PERIOD_SCALE + 2);
  localparam int DW     = (PW_RAW > 8) ? PW_RAW : 8;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequence each request: latch it, run the divisions it needs, then
  // hand the result to the output register.
  ssrseq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Motor state, period registers, the shared divider and the output register.
  ssrseq_dp #(
    .PERIOD_SCALE (PERIOD_SCALE),
    .DW           (DW)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_command          (in_command),
    .in_target_speed     (in_target_speed),
    .in_target_direction (in_target_direction),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_coil_pattern    (out_coil_pattern),
    .out_speed_now       (out_speed_now),
    .out_direction_now   (out_direction_now),
    .out_still_changing  (out_still_changing)
  );

endmodule

// ===== rtl/ssrseq_dp.sv =====
module ssrseq_dp import ssrseq_pkg::*; #(
  parameter int PERIOD_SCALE = 1500,
  parameter int DW           = 11
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_command,
  input  logic [7:0] in_target_speed,
  input  logic       in_target_direction,
  input  dp_cmd_t    cmd,
  output dp_sts_t    sts,
  output logic [3:0] out_coil_pattern,
  output logic [7:0] out_speed_now,
  output logic       out_direction_now,
  output logic       out_still_changing
);

  localparam int CW = $clog2(DW);

  logic          cmd_r, cmd_nxt;
  logic [7:0]    tgt_r, tgt_nxt;
  logic          tdir_r, tdir_nxt;
  logic [7:0]    speed_r, speed_nxt;
  logic          dir_r, dir_nxt;
  logic [DW-1:0] tick_r, tick_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [3:0]    coil_r, coil_nxt;
  logic [DW-1:0] cur_p_r, cur_p_nxt;
  logic [DW-1:0] tgt_p_r, tgt_p_nxt;
  logic [DW-1:0] d_r, d_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] q_r, q_nxt;
  logic [DW-1:0] n_r, n_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  div_dest_t     dest_r, dest_nxt;
  logic [3:0]    oc_r, oc_nxt;
  logic [7:0]    os_r, os_nxt;
  logic          od_r, od_nxt;
  logic          och_r, och_nxt;

  logic [DW-1:0] speed_div;
  logic          new_up;
  logic [DW-1:0] new_p;
  logic [DW-1:0] period;
  logic [DW-1:0] tick_inc;
  logic [1:0]    phase_step;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] q_step;
  logic [7:0]    q_sat;

  assign speed_div  = (speed_r == 8'd0) ? DW'(1) : DW'(speed_r);
  assign new_up     = (dir_r != tdir_r) || (cur_p_r < tgt_p_r);
  assign new_p      = new_up ? (cur_p_r + DW'(1)) : (cur_p_r - DW'(1));
  assign period     = (cur_p_r == '0) ? DW'(1) : cur_p_r;
  assign tick_inc   = tick_r + DW'(1);
  assign phase_step = dir_r ? (phase_r - 2'd1) : (phase_r + 2'd1);

  // One restoring-division step per cycle, dividend bits taken MSB first.
  assign trial  = {rem_r, n_r[DW-1]};
  assign ge     = (trial >= {1'b0, d_r});
  assign diff   = trial - {1'b0, d_r};
  assign q_step = {q_r[DW-2:0], ge};
  assign q_sat  = (q_step > DW'(SPEED_MAX)) ? SPEED_MAX : q_step[7:0];

  always_comb begin
    sts.is_tick         = (cmd_r == CMD_TICK);
    sts.speed_zero      = (speed_r == 8'd0);
    sts.no_change       = (speed_r == tgt_r) && (dir_r == tdir_r);
    sts.tgt_zero        = (tgt_r == 8'd0);
    sts.same_dir        = (dir_r == tdir_r);
    sts.per_eq          = (cur_p_r == tgt_p_r);
    sts.cur_below_scale = (cur_p_r < DW'(PERIOD_SCALE));
    sts.new_p_zero      = (new_p == '0);
    sts.div_done        = done_r;
  end

  always_comb begin
    cmd_nxt   = cmd_r;
    tgt_nxt   = tgt_r;
    tdir_nxt  = tdir_r;
    speed_nxt = speed_r;
    dir_nxt   = dir_r;
    tick_nxt  = tick_r;
    phase_nxt = phase_r;
    coil_nxt  = coil_r;
    cur_p_nxt = cur_p_r;
    tgt_p_nxt = tgt_p_r;
    d_nxt     = d_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    n_nxt     = n_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    dest_nxt  = dest_r;
    oc_nxt    = oc_r;
    os_nxt    = os_r;
    od_nxt    = od_r;
    och_nxt   = och_r;

    if (busy_r) begin
      rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
      q_nxt   = q_step;
      n_nxt   = {n_r[DW-2:0], 1'b0};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        case (dest_r)
          DEST_CUR: cur_p_nxt = q_step;
          DEST_TGT: tgt_p_nxt = q_step;
          DEST_SPD: speed_nxt = q_sat;
          default:  cur_p_nxt = q_step;
        endcase
      end
    end

    case (cmd.op)
      DP_LOAD: begin
        cmd_nxt  = in_command;
        tgt_nxt  = in_target_speed;
        tdir_nxt = in_target_direction;
      end
      DP_DIV_CUR, DP_DIV_TGT, DP_DIV_NEW: begin
        rem_nxt  = '0;
        q_nxt    = '0;
        n_nxt    = DW'(PERIOD_SCALE);
        cnt_nxt  = CW'(DW - 1);
        busy_nxt = 1'b1;
        if (cmd.op == DP_DIV_CUR) begin
          d_nxt    = speed_div;
          dest_nxt = DEST_CUR;
        end else if (cmd.op == DP_DIV_TGT) begin
          d_nxt    = DW'(tgt_r);
          dest_nxt = DEST_TGT;
        end else begin
          d_nxt    = new_p;
          dest_nxt = DEST_SPD;
        end
      end
      DP_TICK_CLR: tick_nxt = '0;
      DP_TICK_STEP: begin
        if (tick_inc < period) begin
          tick_nxt = tick_inc;
        end else begin
          tick_nxt  = '0;
          phase_nxt = phase_step;
          coil_nxt  = (coil_r & ~clr_mask(phase_step)) | set_mask(phase_step);
        end
      end
      DP_STOP: begin
        speed_nxt = 8'd0;
        coil_nxt  = COIL_STOP;
        tick_nxt  = '0;
        dir_nxt   = tdir_r;
      end
      DP_SET_TGT: speed_nxt = tgt_r;
      DP_OUT: begin
        oc_nxt  = coil_r;
        os_nxt  = speed_r;
        od_nxt  = dir_r;
        och_nxt = (speed_r != tgt_r) || (dir_r != tdir_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= 8'd0;
      dir_r   <= 1'b0;
      tick_r  <= '0;
      phase_r <= 2'd0;
      coil_r  <= COIL_STOP;
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      speed_r <= speed_nxt;
      dir_r   <= dir_nxt;
      tick_r  <= tick_nxt;
      phase_r <= phase_nxt;
      coil_r  <= coil_nxt;
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    tgt_r   <= tgt_nxt;
    tdir_r  <= tdir_nxt;
    cur_p_r <= cur_p_nxt;
    tgt_p_r <= tgt_p_nxt;
    d_r     <= d_nxt;
    rem_r   <= rem_nxt;
    q_r     <= q_nxt;
    n_r     <= n_nxt;
    cnt_r   <= cnt_nxt;
    dest_r  <= dest_nxt;
    oc_r    <= oc_nxt;
    os_r    <= os_nxt;
    od_r    <= od_nxt;
    och_r   <= och_nxt;
  end

  assign out_coil_pattern   = oc_r;
  assign out_speed_now      = os_r;
  assign out_direction_now  = od_r;
  assign out_still_changing = och_r;

endmodule

// ===== rtl/ssrseq_ctrl.sv =====
module ssrseq_ctrl import ssrseq_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_WAIT_CUR,
    S_WAIT_TGT,
    S_WAIT_NEW,
    S_OUTPUT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd.op        = DP_NOP;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.op    = DP_LOAD;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.is_tick) begin
          if (sts.speed_zero) begin
            cmd.op    = DP_TICK_CLR;
            state_nxt = S_OUTPUT;
          end else begin
            cmd.op    = DP_DIV_CUR;
            state_nxt = S_WAIT_CUR;
          end
        end else if (sts.no_change) begin
          state_nxt = S_OUTPUT;
        end else if (sts.tgt_zero) begin
          cmd.op    = DP_STOP;
          state_nxt = S_OUTPUT;
        end else begin
          cmd.op    = DP_DIV_CUR;
          state_nxt = S_WAIT_CUR;
        end
      end
      S_WAIT_CUR: begin
        if (sts.div_done) begin
          if (sts.is_tick) begin
            cmd.op    = DP_TICK_STEP;
            state_nxt = S_OUTPUT;
          end else if (sts.same_dir) begin
            cmd.op    = DP_DIV_TGT;
            state_nxt = S_WAIT_TGT;
          end else if (sts.cur_below_scale) begin
            cmd.op    = DP_DIV_NEW;
            state_nxt = S_WAIT_NEW;
          end else begin
            cmd.op    = DP_STOP;
            state_nxt = S_OUTPUT;
          end
        end
      end
      S_WAIT_TGT: begin
        if (sts.div_done) begin
          if (sts.per_eq || sts.new_p_zero) begin
            cmd.op    = DP_SET_TGT;
            state_nxt = S_OUTPUT;
          end else begin
            cmd.op    = DP_DIV_NEW;
            state_nxt = S_WAIT_NEW;
          end
        end
      end
      S_WAIT_NEW: begin
        if (sts.div_done) begin
          state_nxt = S_OUTPUT;
        end
      end
      S_OUTPUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = DP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= (state_nxt == S_IDLE);
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/ssrseq_checker.sv =====
`include "stepper_speed_ramp_sequencer_top_macros.svh"

module ssrseq_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_coil_pattern,
  input logic [7:0] out_speed_now,
  input logic       out_direction_now,
  input logic       out_still_changing
);

  // A waiting result holds until taken.
  `SSRSEQ_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_coil_pattern) && $stable(out_speed_now) && $stable(out_direction_now) && $stable(out_still_changing), "result changed while stalled")

  // One request in flight: no second acceptance straight after one.
  `SSRSEQ_ASSERT(a_one_in_flight, in_valid && in_ready |=> !in_ready, "request accepted while busy")

  // A stopped motor drives all coils high.
  `SSRSEQ_ASSERT(a_stop_coils, out_valid && out_speed_now == 8'd0 |-> out_coil_pattern == 4'hF, "speed zero with coils not released")

  // Reset drops any pending result.
  `SSRSEQ_ASSERT_RST(a_reset_clear, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind stepper_speed_ramp_sequencer_top ssrseq_checker u_ssrseq_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_coil_pattern   (out_coil_pattern),
  .out_speed_now      (out_speed_now),
  .out_direction_now  (out_direction_now),
  .out_still_changing (out_still_changing)
);

// ===== test/stepper_speed_ramp_sequencer_checker.sv =====
module stepper_speed_ramp_sequencer_checker import ssrseq_pkg::*; #(
  parameter int PERIOD_SCALE = 1500
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic       in_command,
  input  logic [7:0] in_target_speed,
  input  logic       in_target_direction,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [3:0] out_coil_pattern,
  input  logic [7:0] out_speed_now,
  input  logic       out_direction_now,
  input  logic       out_still_changing,
  output int         mismatches,
  output int         awaiting
);

  typedef struct packed {
    logic [3:0] coils;
    logic [7:0] speed;
    logic       dir;
    logic       changing;
  } drive_state_t;

  // Coil bits set and cleared on entry to each phase.
  localparam logic [3:0] PHASE_SET [4] = '{4'h2, 4'h1, 4'h8, 4'h4};
  localparam logic [3:0] PHASE_CLR [4] = '{4'h8, 4'h4, 4'h2, 4'h1};

  logic [7:0]   speed;
  logic         dir;
  int unsigned  ticks;
  logic [1:0]   phase;
  logic [3:0]   coils;
  drive_state_t expected_drive[$];
  int           results_seen;

  function automatic int unsigned period_for(input logic [7:0] s);
    return PERIOD_SCALE / ((s == 8'd0) ? 1 : s);
  endfunction

  function automatic logic [7:0] speed_for(input int unsigned p, input logic [7:0] fallback);
    int unsigned s;
    if (p == 0) return fallback;
    s = PERIOD_SCALE / p;
    return (s > 255) ? SPEED_MAX : s[7:0];
  endfunction

  task automatic stop_drive(input logic d);
    speed = 8'd0;
    coils = COIL_STOP;
    ticks = 0;
    dir   = d;
  endtask

  task automatic step_drive(input logic cmd, input logic [7:0] tgt, input logic d,
                            output drive_state_t r);
    int unsigned cur_p, tgt_p, per;
    if (cmd == CMD_TICK) begin
      if (speed == 8'd0) begin
        ticks = 0;
      end else begin
        per = period_for(speed);
        if (per == 0) per = 1;
        ticks = ticks + 1;
        if (ticks >= per) begin
          ticks = 0;
          phase = dir ? phase - 2'd1 : phase + 2'd1;
          coils = (coils & ~PHASE_CLR[phase]) | PHASE_SET[phase];
        end
      end
    end else if (!(speed == tgt && dir == d)) begin
      if (tgt == 8'd0) begin
        stop_drive(d);
      end else begin
        cur_p = period_for(speed);
        tgt_p = period_for(tgt);
        if (dir == d) begin
          if (cur_p == tgt_p) speed = tgt;
          else if (cur_p < tgt_p) speed = speed_for(cur_p + 1, tgt);
          else speed = speed_for(cur_p - 1, tgt);
        end else if (cur_p < PERIOD_SCALE) begin
          speed = speed_for(cur_p + 1, tgt);
        end else begin
          stop_drive(d);
        end
      end
    end
    r = '{coils, speed, dir, (speed != tgt) || (dir != d)};
  endtask

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("result %0d: %s expected %0d, got %0d", results_seen, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    drive_state_t got, want;
    if (!rst_n) begin
      speed = 8'd0;
      dir   = 1'b0;
      ticks = 0;
      phase = 2'd0;
      coils = COIL_STOP;
      expected_drive.delete();
      awaiting = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_coil_pattern, out_speed_now, out_direction_now, out_still_changing};
        results_seen++;
        if (expected_drive.size() == 0) begin
          report_mismatch("result with no request pending, speed", 0, got.speed);
        end else begin
          want = expected_drive.pop_front();
          if (got.coils !== want.coils) report_mismatch("coil_pattern", want.coils, got.coils);
          if (got.speed !== want.speed) report_mismatch("speed_now", want.speed, got.speed);
          if (got.dir !== want.dir) report_mismatch("direction_now", want.dir, got.dir);
          if (got.changing !== want.changing)
            report_mismatch("still_changing", want.changing, got.changing);
        end
      end
      if (in_valid && in_ready) begin
        step_drive(in_command, in_target_speed, in_target_direction, want);
        expected_drive.push_back(want);
      end
      awaiting = expected_drive.size();
    end
  end

endmodule

// ===== test/stepper_speed_ramp_sequencer_top_tb.sv =====
module stepper_speed_ramp_sequencer_top_tb import ssrseq_pkg::*; ();

  // Keep the period scale in one place so the block and the checker agree.
  localparam int PERIOD_SCALE    = 1500;
  // Chance, in percent, that either side idles on a given cycle.
  localparam int IDLE_PCT        = 23;
  localparam int RANDOM_ITEMS    = 880;
  // Long receiver hold-off, long enough to back the block up to its input.
  localparam int HOLD_OFF_CYCLES = 250;
  // Worst ramp request: three divisions plus overhead, with some slack.
  localparam int DRAIN_CYCLES    = 45;
  localparam int CYCLE_LIMIT     = 200_000;

  logic       clk                 = 1'b0;
  logic       rst_n               = 1'b0;
  logic       in_valid            = 1'b0;
  logic       in_ready;
  logic       in_command          = CMD_TICK;
  logic [7:0] in_target_speed     = 8'd0;
  logic       in_target_direction = 1'b0;
  logic       out_valid;
  logic       out_ready           = 1'b0;
  logic [3:0] out_coil_pattern;
  logic [7:0] out_speed_now;
  logic       out_direction_now;
  logic       out_still_changing;

  // Set while neither side may idle.
  logic        calm        = 1'b0;
  int unsigned sent        = 0;
  int unsigned cycle_count = 0;
  int          mismatches;
  int          awaiting;

  always #6 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  stepper_speed_ramp_sequencer_top #(
    .PERIOD_SCALE(PERIOD_SCALE)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_target_speed    (in_target_speed),
    .in_target_direction(in_target_direction),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_coil_pattern   (out_coil_pattern),
    .out_speed_now      (out_speed_now),
    .out_direction_now  (out_direction_now),
    .out_still_changing (out_still_changing)
  );

  stepper_speed_ramp_sequencer_checker #(
    .PERIOD_SCALE(PERIOD_SCALE)
  ) i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_target_speed    (in_target_speed),
    .in_target_direction(in_target_direction),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_coil_pattern   (out_coil_pattern),
    .out_speed_now      (out_speed_now),
    .out_direction_now  (out_direction_now),
    .out_still_changing (out_still_changing),
    .mismatches         (mismatches),
    .awaiting           (awaiting)
  );

  // Offer one request and hold it until the block takes it. Drop valid only
  // when an idle gap is chosen, so valid never falls and rises in one step.
  task automatic offer(input logic cmd, input logic [7:0] tgt, input logic d);
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
    end
    in_valid            <= 1'b1;
    in_command          <= cmd;
    in_target_speed     <= tgt;
    in_target_direction <= d;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // Tick requests carry random targets: still_changing compares with them too.
  task automatic tick_burst(input int unsigned n);
    repeat (n) offer(CMD_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // Receiver: idle at random, but once hold off for a long stretch so that
  // the block fills up and has to stall its input.
  initial begin
    int taken;
    bit held;
    taken = 0;
    held  = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && taken >= 100) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      @(posedge clk);
      if (out_valid && out_ready) taken++;
    end
  end

  // Watchdog: end the run if it has not finished within the limit.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned directed_done;
    int          pick;
    logic [7:0]  aim;
    logic        way;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Ticks at speed zero must hold the count at zero.
    offer(CMD_TICK, 8'd0, 1'b0);
    offer(CMD_TICK, 8'd255, 1'b1);
    // Nothing to change: target already matches.
    offer(CMD_RAMP, 8'd0, 1'b0);
    // Stop request while stopped still takes the new direction.
    offer(CMD_RAMP, 8'd0, 1'b1);
    // Equal periods: speed jumps straight to the target.
    offer(CMD_RAMP, 8'd1, 1'b1);
    offer(CMD_RAMP, 8'd250, 1'b1);
    offer(CMD_RAMP, 8'd255, 1'b1);
    offer(CMD_TICK, 8'd0, 1'b0);
    // Reversal at the slowest period: stop and take the new direction.
    offer(CMD_RAMP, 8'd1, 1'b0);
    offer(CMD_RAMP, 8'd128, 1'b0);
    offer(CMD_RAMP, 8'd1, 1'b0);
    offer(CMD_TICK, 8'd1, 1'b0);
    offer(CMD_TICK, 8'd170, 1'b1);
    offer(CMD_RAMP, 8'd0, 1'b0);
    offer(CMD_RAMP, 8'd255, 1'b0);
    offer(CMD_RAMP, 8'd85, 1'b1);
    offer(CMD_RAMP, 8'd85, 1'b1);
    offer(CMD_TICK, 8'd85, 1'b1);
    directed_done = sent;

    // Random part: mostly well-formed ramp sequences and tick bursts,
    // the rest stop requests, reversals and plain noise.
    while (sent < directed_done + RANDOM_ITEMS) begin
      calm <= (sent >= directed_done + 400) && (sent < directed_done + 600);
      pick = $urandom_range(0, 99);
      way  = 1'($urandom_range(0, 1));
      aim  = ($urandom_range(0, 3) == 0) ? 8'd1 : 8'($urandom_range(1, 255));
      if (pick < 40) begin
        tick_burst($urandom_range(1, 24));
      end else if (pick < 70) begin
        // Approach one target over several ramp requests, ticking between.
        repeat ($urandom_range(1, 4)) begin
          offer(CMD_RAMP, aim, way);
          tick_burst($urandom_range(0, 3));
        end
      end else if (pick < 80) begin
        offer(CMD_RAMP, 8'd0, way);
      end else if (pick < 90) begin
        // One of these is a reversal whatever the present direction.
        offer(CMD_RAMP, aim, way);
        offer(CMD_RAMP, aim, ~way);
        offer(CMD_RAMP, aim, ~way);
      end else begin
        offer(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)));
      end
    end
    calm <= 1'b0;

    // Drain: wait for every expected result, then let the block settle.
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ssrseq_pkg.sv
rtl/ssrseq_dp.sv
rtl/ssrseq_ctrl.sv
rtl/stepper_speed_ramp_sequencer_top.sv
rtl/ssrseq_checker.sv
test/stepper_speed_ramp_sequencer_checker.sv
test/stepper_speed_ramp_sequencer_top_tb.sv
